// ===== hdl/kmst_pkg.sv =====
// kmst_pkg: types and constants for the kruskal spanning tree block
// no dependencies
`default_nettype none
package kmst_pkg;

  localparam int DEF_MAX_VERTICES = 16;
  localparam int DEF_MAX_EDGES    = 64;

  localparam logic [19:0] TOTAL_MAX = 20'hFFFFF;

  localparam logic KIND_EDGE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_RUN_INIT,
    S_RUN_RD,
    S_RUN_LATCH,
    S_FIND_U,
    S_FIND_V,
    S_SUMMARY
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/kruskal_minimum_spanning_tree.sv =====
// kruskal_minimum_spanning_tree: edge store kept sorted on arrival, union-find run on last edge
// depends on kmst_pkg
//
// channel   direction  handshake                 payload
// edge      in         start & !busy             edge_u edge_v weight last_edge
// result    out        strobe (one cycle)        kind tree_u tree_v tree_weight
//                                                total_weight dropped last
// cfg       in         cfg_valid & cfg_ready     cfg_data (num_vertices)
//
// an edge is inserted into the sorted store from the back: each stored edge with a larger key
// is read, compared and shifted up one place, until the front or a key no larger than its own
// a run clears the parent valid bits, then per stored edge reads it, latches it and walks the
// parent memory to the roots of u and v, then sends the summary; each compare waits on the
// registered edge store read port and each walk step on the registered parent memory read port
// no clearing pass after reset; the receiver cannot stall, results are never held back
`default_nettype none
module kruskal_minimum_spanning_tree #(
  parameter int MAX_VERTICES = kmst_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = kmst_pkg::DEF_MAX_EDGES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  edge_u,
  input  wire logic [3:0]  edge_v,
  input  wire logic [15:0] weight,
  input  wire logic        last_edge,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data,
  output logic             strobe,
  output logic             kind,
  output logic [3:0]       tree_u,
  output logic [3:0]       tree_v,
  output logic [15:0]      tree_weight,
  output logic [19:0]      total_weight,
  output logic             dropped,
  output logic             last
);

  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int VW = $clog2(MAX_VERTICES);

  kmst_pkg::state_t state, state_next;

  logic [4:0]    num_vertices;
  logic [CW-1:0] count, count_next;
  logic          drop, drop_next;
  logic          go, go_next;
  logic [23:0]   key, key_next;
  logic [AW-1:0] j, j_next;
  logic [AW-1:0] idx, idx_next;
  logic [23:0]   cur, cur_next;
  logic [VW-1:0] x, x_next;
  logic [VW-1:0] ru, ru_next;
  logic [19:0]   total, total_next;

  logic [23:0]   store [MAX_EDGES];
  logic [23:0]   srd;
  logic          s_we;
  logic [AW-1:0] s_waddr, s_raddr;
  logic [23:0]   s_wdata;

  logic [VW-1:0]           par [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] pvalid;
  logic [VW-1:0]           prd;
  logic                    prv;
  logic [VW-1:0]           p_raddr;
  logic                    p_we;
  logic                    p_clr;

  logic          accept;
  logic          u_bad, v_bad, in_range, keep;
  logic [VW-1:0] p;
  logic [20:0]   sum;

  logic          o_strobe, o_kind, o_last;
  logic [3:0]    o_u, o_v;
  logic [15:0]   o_w;
  logic [19:0]   o_total;

  assign busy      = (state != kmst_pkg::S_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;

  // vertex range check, zero register acts as one
  assign u_bad = ((5'(edge_u) >= num_vertices) && !(num_vertices == 5'd0 && edge_u == 4'd0))
                 || (int'(edge_u) >= MAX_VERTICES);
  assign v_bad = ((5'(edge_v) >= num_vertices) && !(num_vertices == 5'd0 && edge_v == 4'd0))
                 || (int'(edge_v) >= MAX_VERTICES);
  assign in_range = !u_bad && !v_bad;
  assign keep     = in_range && (edge_u != edge_v) && (count != CW'(MAX_EDGES));

  assign p   = prv ? prd : x;
  assign sum = {1'b0, total} + {5'd0, cur[23:8]};

  always_comb begin
    state_next = state;
    unique case (state)
      kmst_pkg::S_IDLE: begin
        if (accept) begin
          if (keep) state_next = kmst_pkg::S_INS_RD;
          else if (last_edge) state_next = kmst_pkg::S_RUN_INIT;
        end
      end
      kmst_pkg::S_INS_RD: begin
        if (j == '0) state_next = go ? kmst_pkg::S_RUN_INIT : kmst_pkg::S_IDLE;
        else state_next = kmst_pkg::S_INS_CMP;
      end
      kmst_pkg::S_INS_CMP: begin
        if (srd > key) state_next = kmst_pkg::S_INS_RD;
        else state_next = go ? kmst_pkg::S_RUN_INIT : kmst_pkg::S_IDLE;
      end
      kmst_pkg::S_RUN_INIT: begin
        state_next = (count == '0) ? kmst_pkg::S_SUMMARY : kmst_pkg::S_RUN_RD;
      end
      kmst_pkg::S_RUN_RD:    state_next = kmst_pkg::S_RUN_LATCH;
      kmst_pkg::S_RUN_LATCH: state_next = kmst_pkg::S_FIND_U;
      kmst_pkg::S_FIND_U: begin
        if (p == x) state_next = kmst_pkg::S_FIND_V;
      end
      kmst_pkg::S_FIND_V: begin
        if (p == x) begin
          state_next = (CW'(idx) == count - CW'(1)) ? kmst_pkg::S_SUMMARY
                                                    : kmst_pkg::S_RUN_RD;
        end
      end
      kmst_pkg::S_SUMMARY: state_next = kmst_pkg::S_IDLE;
      default:             state_next = kmst_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    count_next = count;
    drop_next  = drop;
    go_next    = go;
    key_next   = key;
    j_next     = j;
    idx_next   = idx;
    cur_next   = cur;
    x_next     = x;
    ru_next    = ru;
    total_next = total;
    s_we       = 1'b0;
    s_waddr    = j;
    s_wdata    = key;
    s_raddr    = j - AW'(1);
    p_raddr    = x;
    p_we       = 1'b0;
    p_clr      = 1'b0;
    o_strobe   = 1'b0;
    o_kind     = kmst_pkg::KIND_EDGE;
    o_u        = '0;
    o_v        = '0;
    o_w        = '0;
    o_total    = total;
    o_last     = 1'b0;
    unique case (state)
      kmst_pkg::S_IDLE: begin
        if (accept) begin
          go_next  = last_edge;
          key_next = {weight, edge_u, edge_v};
          j_next   = AW'(count);
          if (!in_range || (edge_u != edge_v && count == CW'(MAX_EDGES))) drop_next = 1'b1;
        end
      end
      kmst_pkg::S_INS_RD: begin
        if (j == '0) begin
          s_we       = 1'b1;
          s_waddr    = '0;
          count_next = count + CW'(1);
        end
      end
      kmst_pkg::S_INS_CMP: begin
        s_we = 1'b1;
        if (srd > key) begin
          s_wdata = srd;
          j_next  = j - AW'(1);
        end else begin
          count_next = count + CW'(1);
        end
      end
      kmst_pkg::S_RUN_INIT: begin
        p_clr      = 1'b1;
        idx_next   = '0;
        total_next = '0;
      end
      kmst_pkg::S_RUN_RD: begin
        s_raddr = idx;
      end
      kmst_pkg::S_RUN_LATCH: begin
        cur_next = srd;
        x_next   = VW'(srd[7:4]);
        p_raddr  = VW'(srd[7:4]);
      end
      kmst_pkg::S_FIND_U: begin
        if (p == x) begin
          ru_next = x;
          x_next  = VW'(cur[3:0]);
          p_raddr = VW'(cur[3:0]);
        end else begin
          x_next  = p;
          p_raddr = p;
        end
      end
      kmst_pkg::S_FIND_V: begin
        if (p == x) begin
          idx_next = idx + AW'(1);
          if (ru != x) begin
            p_we       = 1'b1;
            total_next = sum[20] ? kmst_pkg::TOTAL_MAX : sum[19:0];
            o_strobe   = 1'b1;
            o_u        = cur[7:4];
            o_v        = cur[3:0];
            o_w        = cur[23:8];
            o_total    = sum[20] ? kmst_pkg::TOTAL_MAX : sum[19:0];
          end
        end else begin
          x_next  = p;
          p_raddr = p;
        end
      end
      kmst_pkg::S_SUMMARY: begin
        o_strobe   = 1'b1;
        o_kind     = kmst_pkg::KIND_SUMMARY;
        o_last     = 1'b1;
        count_next = '0;
        drop_next  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_we) store[s_waddr] <= s_wdata;
    srd <= store[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (p_we) par[ru] <= x;
    prd <= par[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= '0;
      prv    <= 1'b0;
    end else begin
      prv <= pvalid[p_raddr];
      if (p_clr) pvalid <= '0;
      else if (p_we) pvalid[ru] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= kmst_pkg::S_IDLE;
      num_vertices <= 5'd16;
      count        <= '0;
      drop         <= 1'b0;
      go           <= 1'b0;
      strobe       <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      drop   <= drop_next;
      go     <= go_next;
      strobe <= o_strobe;
      if (cfg_valid && cfg_ready) num_vertices <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    key          <= key_next;
    j            <= j_next;
    idx          <= idx_next;
    cur          <= cur_next;
    x            <= x_next;
    ru           <= ru_next;
    total        <= total_next;
    kind         <= o_kind;
    tree_u       <= o_u;
    tree_v       <= o_v;
    tree_weight  <= o_w;
    total_weight <= o_total;
    dropped      <= drop;
    last         <= o_last;
  end

`ifndef ASSERT_OFF
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy)) else $error("result without a run");
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> (kind == kmst_pkg::KIND_SUMMARY)) else $error("last on edge result");
  a_idle_after: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy) else $error("busy after summary");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= MAX_EDGES) else $error("edge count overflow");
`endif

endmodule
`default_nettype wire
